/* src/rotate_reflect_blit_address_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotate/reflect blit address core.
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ROTATE_REFLECT_BLIT_ADDRESS_CORE_ASSERT_SVH
`define ROTATE_REFLECT_BLIT_ADDRESS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRBA_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrba: implication check failed");

// The consequent must hold after the antecedent, delayed by the parameter n.
`define RRBA_ASSERT_DELAY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("rrba: delayed check failed");

`endif

/* src/rrba_pkg.sv */
// ----------------------------------------------------------------------------
// rrba_pkg
// Shared widths, register indexes, mode codes and stage types of the
// rotate/reflect blit address core.
// ----------------------------------------------------------------------------
package rrba_pkg;

	localparam int COORD_W    = 13;
	localparam int DIM_W      = 14;
	localparam int PITCH_W    = 17;
	localparam int BPP_W      = 3;
	localparam int OFF_W      = 29;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int PIPE_LAT   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH = 3'd5;

	typedef enum logic [2:0] {
		MODE_IDENT     = 3'd0,
		MODE_REFL_X    = 3'd1,
		MODE_REFL_Y    = 3'd2,
		MODE_REFL_XY   = 3'd3,
		MODE_ROT_PLUS  = 3'd4,
		MODE_ROT_MINUS = 3'd5
	} mode_t;

	localparam logic [2:0] MODE_RESET = 3'd0;
	localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
	localparam logic [DIM_W-1:0] WIDTH_RESET = 14'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd768;
	localparam logic [PITCH_W-1:0] PITCH_RESET = 17'd4096;

	typedef struct packed {
		logic [2:0]         mode;
		logic [BPP_W-1:0]   bpp;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [PITCH_W-1:0] src_pitch;
		logic [PITCH_W-1:0] dst_pitch;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               last;
		logic               bad;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIM_W-1:0]   row;
		logic [DIM_W-1:0]   col;
	} s1_t;

	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic                     bad;
		logic [OFF_W-1:0]         src_row;
		logic [COORD_W+BPP_W-1:0] src_col;
		logic [OFF_W-1:0]         dst_row;
		logic [DIM_W+BPP_W-1:0]   dst_col;
	} s2_t;

	// Pixel size zero behaves as one byte, anything above four as four.
	function automatic logic [BPP_W-1:0] bpp_clamp(input logic [BPP_W-1:0] raw);
		logic [BPP_W-1:0] res;
		if (raw == '0) begin
			res = BPP_W'(1);
		end else if (raw > BPP_W'(4)) begin
			res = BPP_W'(4);
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

/* src/rrba_map.sv */
// ----------------------------------------------------------------------------
// rrba_map
// First stage: maps the source coordinate to the destination row and column
// for the selected mode and flags positions outside the destination.
// ----------------------------------------------------------------------------
module rrba_map import rrba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [COORD_W-1:0] px,
	input  logic [COORD_W-1:0] py,
	input  logic               last,
	input  cfg_t               cfg,
	output s1_t                s1
);

	logic [DIM_W-1:0] xe;
	logic [DIM_W-1:0] ye;
	logic [DIM_W-1:0] w_m1_x;
	logic [DIM_W-1:0] w_m1_y;
	logic [DIM_W-1:0] h_m1_x;
	logic [DIM_W-1:0] h_m1_y;
	logic             bad_std;
	logic             bad_rot;
	logic             bad;
	logic [DIM_W-1:0] row;
	logic [DIM_W-1:0] col;
	mode_t            mode;

	assign xe = DIM_W'(px);
	assign ye = DIM_W'(py);
	assign w_m1_x = cfg.width - DIM_W'(1) - xe;
	assign w_m1_y = cfg.width - DIM_W'(1) - ye;
	assign h_m1_x = cfg.height - DIM_W'(1) - xe;
	assign h_m1_y = cfg.height - DIM_W'(1) - ye;
	assign bad_std = (xe >= cfg.width) || (ye >= cfg.height);
	assign bad_rot = (xe >= cfg.height) || (ye >= cfg.width);
	assign mode = mode_t'(cfg.mode);

	// Unused mode codes fall back to the identity mapping.
	always_comb begin
		unique case (mode)
			MODE_REFL_X: begin
				bad = bad_std;
				row = ye;
				col = w_m1_x;
			end
			MODE_REFL_Y: begin
				bad = bad_std;
				row = h_m1_y;
				col = xe;
			end
			MODE_REFL_XY: begin
				bad = bad_std;
				row = h_m1_y;
				col = w_m1_x;
			end
			MODE_ROT_PLUS: begin
				bad = bad_rot;
				row = xe;
				col = w_m1_y;
			end
			MODE_ROT_MINUS: begin
				bad = bad_rot;
				row = h_m1_x;
				col = ye;
			end
			default: begin
				bad = bad_std;
				row = ye;
				col = xe;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else begin
			s1.valid <= in_valid;
			s1.last  <= last;
			s1.bad   <= bad;
			s1.x     <= px;
			s1.y     <= py;
			s1.row   <= row;
			s1.col   <= col;
		end
	end

endmodule

/* src/rrba_mul.sv */
// ----------------------------------------------------------------------------
// rrba_mul
// Second stage: multiplies rows by the pitches and columns by the pixel size.
// ----------------------------------------------------------------------------
module rrba_mul import rrba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  s1_t  s1,
	output s2_t  s2
);

	logic [COORD_W+PITCH_W-1:0] src_row_full;
	logic [DIM_W+PITCH_W-1:0]   dst_row_full;
	logic [COORD_W+BPP_W-1:0]   src_col;
	logic [DIM_W+BPP_W-1:0]     dst_col;

	assign src_row_full = (COORD_W+PITCH_W)'(s1.y) * (COORD_W+PITCH_W)'(cfg.src_pitch);
	assign dst_row_full = (DIM_W+PITCH_W)'(s1.row) * (DIM_W+PITCH_W)'(cfg.dst_pitch);
	assign src_col      = (COORD_W+BPP_W)'(s1.x) * (COORD_W+BPP_W)'(cfg.bpp);
	assign dst_col      = (DIM_W+BPP_W)'(s1.col) * (DIM_W+BPP_W)'(cfg.bpp);

	// Offsets wrap at the offset width, so the high product bits are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else begin
			s2.valid   <= s1.valid;
			s2.last    <= s1.last;
			s2.bad     <= s1.bad;
			s2.src_row <= src_row_full[OFF_W-1:0];
			s2.dst_row <= dst_row_full[OFF_W-1:0];
			s2.src_col <= src_col;
			s2.dst_col <= dst_col;
		end
	end

endmodule

/* src/rrba_sum.sv */
// ----------------------------------------------------------------------------
// rrba_sum
// Third stage: adds row and column terms and registers the result strobe.
// ----------------------------------------------------------------------------
module rrba_sum import rrba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  s2_t              s2,
	output logic             done,
	output logic [OFF_W-1:0] src_offset,
	output logic [OFF_W-1:0] dst_offset,
	output logic             out_of_range,
	output logic             last_out
);

	logic [OFF_W-1:0] src_sum;
	logic [OFF_W-1:0] dst_sum;

	assign src_sum = s2.src_row + OFF_W'(s2.src_col);
	assign dst_sum = s2.dst_row + OFF_W'(s2.dst_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= s2.valid;
		end
	end

	// A position outside the destination reports both offsets as zero.
	always_ff @(posedge clk) begin
		src_offset   <= s2.bad ? '0 : src_sum;
		dst_offset   <= s2.bad ? '0 : dst_sum;
		out_of_range <= s2.bad;
		last_out     <= s2.last;
	end

endmodule

/* src/rotate_reflect_blit_address_core.sv */
// An accepted request is registered in s1, then in s2, and then shows its result with done.
// Throughput: one request per cycle, every cycle, through a three-stage pipeline
// (mapping, multiplication, addition); busy is never raised.
// Reset clears the stage valid bits and done and returns the configuration to its defaults.
// Results cannot be held off, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
// rotate_reflect_blit_address_core
// Computes shadow-buffer read and framebuffer write byte offsets for one
// source pixel under identity, reflection or rotation.
// ----------------------------------------------------------------------------
`include "rotate_reflect_blit_address_core_assert.svh"

module rotate_reflect_blit_address_core import rrba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_W-1:0]    px,
	input  logic [COORD_W-1:0]    py,
	input  logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [OFF_W-1:0]      src_offset,
	output logic [OFF_W-1:0]      dst_offset,
	output logic                  out_of_range,
	output logic                  last_out
);

	cfg_t cfg_q;
	s1_t  s1;
	s2_t  s2;
	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_RESET;
			cfg_q.bpp       <= BPP_RESET;
			cfg_q.width     <= WIDTH_RESET;
			cfg_q.height    <= HEIGHT_RESET;
			cfg_q.src_pitch <= PITCH_RESET;
			cfg_q.dst_pitch <= PITCH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:      cfg_q.mode      <= cfg_data[2:0];
				REG_BPP:       cfg_q.bpp       <= bpp_clamp(cfg_data[BPP_W-1:0]);
				REG_WIDTH:     cfg_q.width     <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    cfg_q.height    <= cfg_data[DIM_W-1:0];
				REG_SRC_PITCH: cfg_q.src_pitch <= cfg_data[PITCH_W-1:0];
				REG_DST_PITCH: cfg_q.dst_pitch <= cfg_data[PITCH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rrba_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.px       (px),
		.py       (py),
		.last     (last),
		.cfg      (cfg_q),
		.s1       (s1)
	);

	rrba_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.s1     (s1),
		.s2     (s2)
	);

	rrba_sum u_sum (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2           (s2),
		.done         (done),
		.src_offset   (src_offset),
		.dst_offset   (dst_offset),
		.out_of_range (out_of_range),
		.last_out     (last_out)
	);

	// Every accepted request raises done when it leaves the pipeline, and nothing else raises done.
	`RRBA_ASSERT_DELAY(a_req_done, accept, PIPE_LAT, done)
	`RRBA_ASSERT_IMPLY(a_done_req, done, $past(accept, PIPE_LAT))
	`RRBA_ASSERT_IMPLY(a_oor_zero, done && out_of_range, src_offset == '0 && dst_offset == '0)
	`RRBA_ASSERT_IMPLY(a_stage_chain, s2.valid, $past(s1.valid))

endmodule
